// ===== sv/kmd_pkg.sv =====
// kmd_pkg: shared types and constants for the key matrix debounce scanner
// no dependencies; used by kmd_integrator, kmd_key_store and the top level
`timescale 1ns / 1ps

package kmd_pkg;

  localparam int unsigned Rows      = 4;
  localparam int unsigned Cols      = 6;
  localparam int unsigned NumKeys   = Rows * Cols;
  localparam int unsigned IdxW      = $clog2(NumKeys);
  localparam int unsigned RowW      = 2;
  localparam int unsigned ColW      = 3;
  localparam int unsigned LevelsW   = 24;
  localparam int unsigned CountW    = 4;

  localparam logic [CountW-1:0] DebounceReset = 4'd5;

  typedef enum logic [1:0] {
    EvNone    = 2'd0,
    EvPress   = 2'd1,
    EvRelease = 2'd2
  } kmd_event_e;

  // result of one integrator step
  typedef struct packed {
    logic [CountW-1:0] count;
    logic              settled;
    logic              level;
  } kmd_integ_t;

  // write request into the per-key store
  typedef struct packed {
    logic [IdxW-1:0]   idx;
    logic              cnt_we;
    logic [CountW-1:0] cnt;
    logic              stable_we;
    logic              stable;
  } kmd_wr_t;

endpackage

// ===== sv/kmd_integrator.sv =====
// kmd_integrator: the shared saturating counter step, used once per visited key
// depends on kmd_pkg
`timescale 1ns / 1ps

module kmd_integrator (
  input  logic [kmd_pkg::CountW-1:0] count_i,
  input  logic                       pressed_i,
  input  logic [kmd_pkg::CountW-1:0] dmax_i,
  output kmd_pkg::kmd_integ_t        result_o
);

  logic [kmd_pkg::CountW-1:0] top;
  logic [kmd_pkg::CountW-1:0] next;

  always_comb begin
    // a zero register value acts as one
    top = (dmax_i == '0) ? kmd_pkg::CountW'(1) : dmax_i;
    if (pressed_i) begin
      // a count above top (top lowered without reset) snaps to top
      next = (count_i < top) ? count_i + kmd_pkg::CountW'(1) : top;
      result_o.settled = (next == top);
      result_o.level   = 1'b1;
    end else begin
      next = (count_i != '0) ? count_i - kmd_pkg::CountW'(1) : '0;
      result_o.settled = (next == '0);
      result_o.level   = 1'b0;
    end
    result_o.count = next;
  end

endmodule

// ===== sv/kmd_key_store.sv =====
// kmd_key_store: per-key integrator counts and debounced states, one read port and one write port
// depends on kmd_pkg
`timescale 1ns / 1ps

module kmd_key_store (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [kmd_pkg::IdxW-1:0]   rd_idx_i,
  output logic [kmd_pkg::CountW-1:0] rd_cnt_o,
  output logic                       rd_stable_o,
  input  kmd_pkg::kmd_wr_t           wr_i
);

  logic [kmd_pkg::CountW-1:0] cnt_q    [kmd_pkg::NumKeys];
  logic                       stable_q [kmd_pkg::NumKeys];

  assign rd_cnt_o    = cnt_q[rd_idx_i];
  assign rd_stable_o = stable_q[rd_idx_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < kmd_pkg::NumKeys; i++) begin
        cnt_q[i]    <= '0;
        stable_q[i] <= 1'b0;
      end
    end else begin
      if (wr_i.cnt_we) begin
        cnt_q[wr_i.idx] <= wr_i.cnt;
      end
      if (wr_i.stable_we) begin
        stable_q[wr_i.idx] <= wr_i.stable;
      end
    end
  end

endmodule

// ===== sv/key_matrix_debounce_scanner.sv =====
// key_matrix_debounce_scanner: top level, scan sequencer and output register
// depends on kmd_pkg, kmd_integrator, kmd_key_store
`timescale 1ns / 1ps

// Takes one 24-bit matrix snapshot per input beat (bit row*6+col, 1 = pressed)
// and walks the 4x6 keys in row-major order, one key per clock, through a
// single shared saturating integrator. The walk stops at the first key whose
// settled level differs from its debounced state and reports it as a press or
// release; otherwise a none event is reported. A snapshot is accepted, then
// 1 to 24 keys are visited, then the result is loaded into the output
// register once that register is free. The block is not ready while a walk is
// running or its result waits to be loaded; a finished result may wait in the
// output register while the next snapshot is taken. Counts and states clear at
// reset; reset again after changing the debounce top.
module key_matrix_debounce_scanner (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [kmd_pkg::CountW-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [kmd_pkg::LevelsW-1:0] key_levels_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  event_kind_o,
  output logic [kmd_pkg::RowW-1:0]    key_row_o,
  output logic [kmd_pkg::ColW-1:0]    key_col_o
);

  typedef enum logic [1:0] {
    StIdle,
    StWalk,
    StEmit
  } state_e;

  state_e                      state_q;
  logic [kmd_pkg::CountW-1:0]  dmax_q;
  logic [kmd_pkg::LevelsW-1:0] levels_q;
  logic [kmd_pkg::IdxW-1:0]    idx_q;
  logic [kmd_pkg::RowW-1:0]    row_q;
  logic [kmd_pkg::ColW-1:0]    col_q;
  kmd_pkg::kmd_event_e         res_kind_q;
  logic [kmd_pkg::RowW-1:0]    res_row_q;
  logic [kmd_pkg::ColW-1:0]    res_col_q;
  logic                        out_valid_q;
  kmd_pkg::kmd_event_e         out_kind_q;
  logic [kmd_pkg::RowW-1:0]    out_row_q;
  logic [kmd_pkg::ColW-1:0]    out_col_q;

  logic [kmd_pkg::CountW-1:0]  rd_cnt;
  logic                        rd_stable;
  kmd_pkg::kmd_integ_t         integ;
  kmd_pkg::kmd_wr_t            wr;
  logic                        changed;
  logic                        out_load;

  kmd_key_store u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_idx_i    (idx_q),
    .rd_cnt_o    (rd_cnt),
    .rd_stable_o (rd_stable),
    .wr_i        (wr)
  );

  kmd_integrator u_integ (
    .count_i   (rd_cnt),
    .pressed_i (levels_q[idx_q]),
    .dmax_i    (dmax_q),
    .result_o  (integ)
  );

  always_comb begin
    changed      = integ.settled && (integ.level != rd_stable);
    wr.idx       = idx_q;
    wr.cnt_we    = (state_q == StWalk);
    wr.cnt       = integ.count;
    wr.stable_we = (state_q == StWalk) && changed;
    wr.stable    = integ.level;
    out_load     = (state_q == StEmit) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dmax_q <= kmd_pkg::DebounceReset;
    end else if (cfg_we_i) begin
      dmax_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      row_q       <= '0;
      col_q       <= '0;
      levels_q    <= '0;
      res_kind_q  <= kmd_pkg::EvNone;
      res_row_q   <= '0;
      res_col_q   <= '0;
      out_kind_q  <= kmd_pkg::EvNone;
      out_row_q   <= '0;
      out_col_q   <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            levels_q <= key_levels_i;
            idx_q    <= '0;
            row_q    <= '0;
            col_q    <= '0;
            state_q  <= StWalk;
          end
        end
        StWalk: begin
          if (changed) begin
            res_kind_q <= integ.level ? kmd_pkg::EvPress : kmd_pkg::EvRelease;
            res_row_q  <= row_q;
            res_col_q  <= col_q;
            state_q    <= StEmit;
          end else if (idx_q == kmd_pkg::IdxW'(kmd_pkg::NumKeys - 1)) begin
            res_kind_q <= kmd_pkg::EvNone;
            res_row_q  <= '0;
            res_col_q  <= '0;
            state_q    <= StEmit;
          end else begin
            idx_q <= idx_q + kmd_pkg::IdxW'(1);
            if (col_q == kmd_pkg::ColW'(kmd_pkg::Cols - 1)) begin
              col_q <= '0;
              row_q <= row_q + kmd_pkg::RowW'(1);
            end else begin
              col_q <= col_q + kmd_pkg::ColW'(1);
            end
          end
        end
        StEmit: begin
          // wait for the output register to free up
          if (out_load) begin
            out_kind_q  <= res_kind_q;
            out_row_q   <= res_row_q;
            out_col_q   <= res_col_q;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign in_ready_o   = (state_q == StIdle);
  assign out_valid_o  = out_valid_q;
  assign event_kind_o = out_kind_q;
  assign key_row_o    = out_row_q;
  assign key_col_o    = out_col_q;

  // a none event never names a key
  a_none_at_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (event_kind_o == kmd_pkg::EvNone)) |->
      (key_row_o == '0 && key_col_o == '0))
    else $error("none event with nonzero key position");

  // walk index and row/col counters stay in step
  a_idx_tracks_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWalk) |->
      (32'(idx_q) == 32'(row_q) * kmd_pkg::Cols + 32'(col_q) &&
       32'(idx_q) < kmd_pkg::NumKeys))
    else $error("walk index out of step with row/col");

  // an accepted snapshot starts a walk, so the block drops ready
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready held after accepting a snapshot");

endmodule

// ===== tb/testbench.sv =====
// testbench: self-checking bench for key_matrix_debounce_scanner
// depends on kmd_pkg and the key_matrix_debounce_scanner rtl; holds its own scan predictor
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned StallLimit = 3000;
  localparam int unsigned HoldLen    = 300;
  localparam int unsigned TailCycles = 40;

  typedef struct {
    kmd_pkg::kmd_event_e      kind;
    logic [kmd_pkg::RowW-1:0] row;
    logic [kmd_pkg::ColW-1:0] col;
  } key_event_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [kmd_pkg::CountW-1:0]    cfg_wdata_i;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic [kmd_pkg::LevelsW-1:0]   key_levels_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic [1:0]                    event_kind_o;
  logic [kmd_pkg::RowW-1:0]      key_row_o;
  logic [kmd_pkg::ColW-1:0]      key_col_o;

  // predictor state, mirrors the per-key counters and debounced levels
  logic [kmd_pkg::CountW-1:0] integ_count [kmd_pkg::NumKeys];
  bit                         key_down    [kmd_pkg::NumKeys];
  logic [kmd_pkg::CountW-1:0] debounce_top_q;

  key_event_t expected_events[$];

  bit idle_mode;
  bit hold_req;
  int error_count;
  int snapshots_sent;
  int events_checked;
  int press_seen;
  int release_seen;
  int idle_cycles;

  key_matrix_debounce_scanner dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .key_levels_i (key_levels_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .event_kind_o (event_kind_o),
    .key_row_o    (key_row_o),
    .key_col_o    (key_col_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // one scan of the matrix: integrate keys in row-major order, stop at first change
  function automatic key_event_t scan_matrix(input logic [kmd_pkg::LevelsW-1:0] levels);
    key_event_t                 res;
    logic [kmd_pkg::CountW-1:0] top;
    int unsigned                r;
    int unsigned                c;
    int unsigned                k;
    bit                         found;
    bit                         settled;
    bit                         lvl;
    top = (debounce_top_q == '0) ? kmd_pkg::CountW'(1) : debounce_top_q;
    res.kind = kmd_pkg::EvNone;
    res.row  = '0;
    res.col  = '0;
    found = 1'b0;
    for (r = 0; r < kmd_pkg::Rows && !found; r++) begin
      for (c = 0; c < kmd_pkg::Cols && !found; c++) begin
        k = r * kmd_pkg::Cols + c;
        lvl = levels[k];
        if (lvl) begin
          // a counter left above a lowered top snaps to the top
          if (integ_count[k] < top) integ_count[k] = integ_count[k] + 1'b1;
          else integ_count[k] = top;
          settled = (integ_count[k] == top);
        end else begin
          if (integ_count[k] != '0) integ_count[k] = integ_count[k] - 1'b1;
          settled = (integ_count[k] == '0);
        end
        if (settled && lvl != key_down[k]) begin
          key_down[k] = lvl;
          res.kind = lvl ? kmd_pkg::EvPress : kmd_pkg::EvRelease;
          res.row  = kmd_pkg::RowW'(r);
          res.col  = kmd_pkg::ColW'(c);
          found = 1'b1;
        end
      end
    end
    return res;
  endfunction

  // sends one snapshot beat and records the event it must produce
  task automatic send_levels(input logic [kmd_pkg::LevelsW-1:0] levels);
    int gap;
    if (idle_mode && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    key_levels_i <= levels;
    do @(posedge clk_i); while (!in_ready_o);
    expected_events.push_back(scan_matrix(levels));
    snapshots_sent++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_debounce(input logic [kmd_pkg::CountW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    debounce_top_q = value;
    cfg_we_i <= 1'b0;
  endtask

  // bounded sequences: a held pattern, some contact bounce, occasional garbage
  task automatic run_scan_phase(input logic [kmd_pkg::CountW-1:0] dbv, input int count,
                                input bit last);
    logic [kmd_pkg::LevelsW-1:0] held;
    logic [kmd_pkg::LevelsW-1:0] snap;
    int                          eff;
    int                          hold_left;
    int                          nflip;
    int                          i;
    eff = (dbv == '0) ? 1 : int'(dbv);
    held = kmd_pkg::LevelsW'($urandom & $urandom);
    hold_left = 0;
    for (i = 0; i < count; i++) begin
      idle_mode = !last && ((i / 60) % 2 == 0);
      if ($urandom_range(0, 99) < 8) begin
        snap = kmd_pkg::LevelsW'($urandom);
      end else begin
        if (hold_left == 0) begin
          case ($urandom_range(0, 9))
            0: held = '0;
            1: held = '1;
            default: begin
              nflip = $urandom_range(1, 3);
              repeat (nflip) held[$urandom_range(0, kmd_pkg::LevelsW - 1)] ^= 1'b1;
            end
          endcase
          hold_left = $urandom_range(eff, 3 * eff + 4);
        end
        hold_left--;
        snap = held;
        if ($urandom_range(0, 4) == 0) snap[$urandom_range(0, kmd_pkg::LevelsW - 1)] ^= 1'b1;
      end
      send_levels(snap);
    end
  endtask

  task automatic test_directed();
    int i;
    idle_mode = 1'b1;
    send_levels('0);
    for (i = 0; i < 6; i++) send_levels('1);
    for (i = 0; i < 6; i++) send_levels('0);
    send_levels(24'h800000);
    for (i = 0; i < 3; i++) send_levels(24'hAAAAAA);
    for (i = 0; i < 3; i++) send_levels(24'h555555);
    wait_idle();
  endtask

  task automatic test_debounce_settings();
    int i;
    idle_mode = 1'b1;
    write_debounce(4'd15);
    for (i = 0; i < 17; i++) send_levels('1);
    wait_idle();
    // lowered without reset, so pressed counters sit above the new top
    write_debounce(4'd2);
    for (i = 0; i < 3; i++) send_levels('1);
    for (i = 0; i < 4; i++) send_levels('0);
    wait_idle();
    // zero behaves as a top of one
    write_debounce(4'd0);
    send_levels(24'h000001);
    send_levels(24'h000000);
    send_levels(24'h800000);
    send_levels(24'h000000);
    wait_idle();
    write_debounce(4'd1);
    send_levels(24'h800000);
    send_levels(24'hFFFFFF);
    send_levels(24'h000000);
    wait_idle();
  endtask

  task automatic test_backpressure();
    int i;
    idle_mode = 1'b0;
    hold_req = 1'b1;
    for (i = 0; i < 10; i++) send_levels(kmd_pkg::LevelsW'($urandom));
    wait_idle();
  endtask

  task automatic test_random_scans();
    logic [kmd_pkg::CountW-1:0] settings [6];
    int p;
    settings = '{4'd1, 4'd15, 4'd3, 4'd0, 4'd8, 4'd5};
    settings[3] = kmd_pkg::CountW'($urandom_range(2, 14));
    for (p = 0; p < 6; p++) begin
      write_debounce(settings[p]);
      run_scan_phase(settings[p], 175, p == 5);
      wait_idle();
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    key_event_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_events.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result beat: kind %0d row %0d col %0d",
                   event_kind_o, key_row_o, key_col_o);
      end else begin
        want = expected_events.pop_front();
        events_checked++;
        if (want.kind == kmd_pkg::EvPress) press_seen++;
        if (want.kind == kmd_pkg::EvRelease) release_seen++;
        if (event_kind_o != want.kind || key_row_o != want.row || key_col_o != want.col) begin
          error_count++;
          if (error_count <= 10)
            $display("mismatch: expected kind %0d row %0d col %0d, %s %0d row %0d col %0d",
                     want.kind, want.row, want.col, "got kind",
                     event_kind_o, key_row_o, key_col_o);
        end
      end
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin : receiver
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_left = HoldLen;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (idle_mode && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // watchdog: cycles with no beat on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("timeout after %0d cycles without a beat", idle_cycles);
        $display("testbench: errors");
        $finish;
      end
    end
  end

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    key_levels_i = '0;
    idle_mode    = 1'b0;
    hold_req     = 1'b0;
    error_count  = 0;
    snapshots_sent = 0;
    events_checked = 0;
    press_seen   = 0;
    release_seen = 0;
    idle_cycles  = 0;
    debounce_top_q = kmd_pkg::DebounceReset;
    for (int k = 0; k < kmd_pkg::NumKeys; k++) begin
      integ_count[k] = '0;
      key_down[k] = 1'b0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_debounce_settings();
    test_backpressure();
    test_random_scans();

    wait_idle();
    repeat (TailCycles) @(posedge clk_i);
    if (expected_events.size() != 0) begin
      error_count += expected_events.size();
      $display("%0d expected results never arrived", expected_events.size());
    end
    $display("summary: %0d snapshots, %0d results checked (%0d presses, %0d releases)",
             snapshots_sent, events_checked, press_seen, release_seen);
    $display("debounce tops 0 to 15 incl. lowered without reset, %0d errors", error_count);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ===== key_matrix_debounce_scanner.f =====
sv/kmd_pkg.sv
sv/kmd_integrator.sv
sv/kmd_key_store.sv
sv/key_matrix_debounce_scanner.sv
tb/testbench.sv
